[design/phpt_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse half-peak timing counter: shared definitions
// Field widths, register indexes, result kinds and the types that pass
// between the sample cells, the result queue and the top level.
// ----------------------------------------------------------------------------
package phpt_pkg;

   // Field widths
   localparam int VALUE_W = 16;
   localparam int TIME_W  = 32;
   localparam int T2_W    = 33;
   localparam int HITS_W  = 16;
   localparam int LEVEL_W = 17;

   // Configuration register indexes
   localparam logic [1:0] CSR_BASELINE  = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_WIN_START = 2'd2;
   localparam logic [1:0] CSR_WIN_END   = 2'd3;

   // Register reset values
   localparam logic [VALUE_W-1:0] BASELINE_RESET  = 16'sd0;
   localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 16'sd100;
   localparam logic [TIME_W-1:0]  WIN_START_RESET = 32'h0000_0000;
   localparam logic [TIME_W-1:0]  WIN_END_RESET   = 32'hFFFF_FFFF;

   // Result kinds
   localparam logic KIND_DETECT = 1'b0;
   localparam logic KIND_COUNT  = 1'b1;

   // Saturation limit of the hit counter
   localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;

   // Control broadcast to every sample cell
   typedef struct packed {
      logic                       shift;     // take the neighbour's sample
      logic                       evaluate;  // compare against the half level
      logic                       rising;    // positive pulse polarity
      logic signed [LEVEL_W-1:0]  level;     // peak plus baseline
   } cell_ctl_type;

   // One result item
   typedef struct packed {
      logic              kind;
      logic [T2_W-1:0]   time_x2;
      logic              in_window;
      logic [HITS_W-1:0] hits;
      logic              last;
   } result_type;

endpackage

[design/pulse_half_peak_timing_counter_top.sv]
// ----------------------------------------------------------------------------
// Pulse half-peak timing counter
// 50 percent constant fraction timing on a stream of digitizer samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the req_ channel, one transfer per sample, with tlast on
// the last sample of a record. Results leave on the rsp_ channel: tuser 0 is
// a pulse detection (doubled time and window flag), tuser 1 is the hit count
// at record end; rsp_tlast marks the final result of one sample.
// Registers must be written by the user on the csr_ channel only while the
// block is idle; the block itself does not enforce this. A sample that closes
// no pulse holds off the input only while the result queue is full. One that
// closes a pulse holds it off while the cell compare, the one-hot selection,
// the time sum and the window test run in turn, and for the count when it
// also ends the record. A count result is pushed in the same cycle as its
// transfer unless that sample closes a pulse; detections in the window test.
// A two-entry result queue parts the two sides; the input is held off while
// the queue is full, so a stalled receiver stalls the input and nothing is
// lost. Synchronous reset restores the configuration and control registers.
// ----------------------------------------------------------------------------
module pulse_half_peak_timing_counter_top #(
   parameter int PULSE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: sample_value [15:0], sample_time [47:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: detect_time_x2 [32:0], in_window [33], hit_count [49:34],
   // zero [55:50]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,
   // rsp_tuser: item_kind [0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int CNT_W = $clog2(PULSE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_SELECT = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_WINDOW = 3'd4;
   localparam logic [2:0] ST_COUNT  = 3'd5;

   // Configuration registers
   logic signed [phpt_pkg::VALUE_W-1:0] baseline_ff, threshold_ff;
   logic [phpt_pkg::TIME_W-1:0]         win_start_ff, win_end_ff;

   // Control state
   logic [2:0]                          state_ff, state_in;
   logic                                in_pulse_ff, in_pulse_in;
   logic signed [phpt_pkg::VALUE_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [phpt_pkg::TIME_W-1:0]         prev_time_ff, prev_time_in;
   logic [phpt_pkg::HITS_W-1:0]         hits_ff, hits_in;
   logic                                eor_pend_ff, eor_pend_in;

   // Search datapath
   logic [phpt_pkg::TIME_W-1:0]         sel_time_ff, sel_prev_ff;
   logic [phpt_pkg::TIME_W-1:0]         sel_time_any, sel_prev_any;
   logic [phpt_pkg::T2_W-1:0]           t2_ff, t2_in;

   // Input fields and decode
   logic signed [phpt_pkg::VALUE_W-1:0] sample_value;
   logic [phpt_pkg::TIME_W-1:0]         sample_time;
   logic                                req_fire;
   logic                                rising;
   logic                                over;
   logic                                close_pulse;
   logic                                start_pulse;
   logic                                store;
   logic                                in_window;
   logic signed [phpt_pkg::LEVEL_W-1:0] level;

   // Cell row
   phpt_pkg::cell_ctl_type              cell_ctl;
   logic signed [phpt_pkg::VALUE_W-1:0] cell_value [PULSE_DEPTH];
   logic [phpt_pkg::TIME_W-1:0]         cell_time  [PULSE_DEPTH];
   logic [phpt_pkg::TIME_W-1:0]         cell_prev  [PULSE_DEPTH];
   logic [phpt_pkg::TIME_W-1:0]         cell_sel_time [PULSE_DEPTH];
   logic [phpt_pkg::TIME_W-1:0]         cell_sel_prev [PULSE_DEPTH];
   logic [PULSE_DEPTH-1:0]              cell_hit;
   logic [PULSE_DEPTH-1:0]              sel_vec;

   // Result queue
   logic                                q_push;
   logic                                q_full;
   phpt_pkg::result_type                q_data;
   phpt_pkg::result_type                rsp_data;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff  <= phpt_pkg::BASELINE_RESET;
         threshold_ff <= phpt_pkg::THRESHOLD_RESET;
         win_start_ff <= phpt_pkg::WIN_START_RESET;
         win_end_ff   <= phpt_pkg::WIN_END_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            phpt_pkg::CSR_BASELINE:  baseline_ff  <= csr_data[15:0];
            phpt_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[15:0];
            phpt_pkg::CSR_WIN_START: win_start_ff <= csr_data;
            phpt_pkg::CSR_WIN_END:   win_end_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input decode and pulse classification.
   always_comb begin
      sample_value = req_tdata[15:0];
      sample_time  = req_tdata[47:16];
      req_tready   = (state_ff == ST_IDLE) && !q_full;
      req_fire     = req_tvalid && req_tready;
      rising       = threshold_ff > baseline_ff;
      over         = rising ? (sample_value > threshold_ff) : (sample_value < threshold_ff);
      close_pulse  = in_pulse_ff && !over;
      start_pulse  = !in_pulse_ff && over;
      store        = req_fire && (start_pulse ||
                     (in_pulse_ff && over && (count_ff < CNT_W'(PULSE_DEPTH))));
      level        = $signed({peak_ff[phpt_pkg::VALUE_W-1], peak_ff}) +
                     $signed({baseline_ff[phpt_pkg::VALUE_W-1], baseline_ff});
      in_window    = (t2_ff > {win_start_ff, 1'b0}) && (t2_ff < {win_end_ff, 1'b0});
   end

   // Broadcast control for the cell row.
   always_comb begin
      cell_ctl.shift    = store;
      cell_ctl.evaluate = (state_ff == ST_MATCH);
      cell_ctl.rising   = rising;
      cell_ctl.level    = level;
   end

   // Row of sample cells; the newest sample sits in cell 0.
   for (genvar i = 0; i < PULSE_DEPTH; i++) begin : g_cell
      logic signed [phpt_pkg::VALUE_W-1:0] value_src;
      logic [phpt_pkg::TIME_W-1:0]         time_src;
      logic [phpt_pkg::TIME_W-1:0]         prev_src;
      logic                                older_hit;

      if (i == 0) begin : g_head
         assign value_src = sample_value;
         assign time_src  = sample_time;
         assign prev_src  = prev_time_ff;
      end else begin : g_body
         assign value_src = cell_value[i-1];
         assign time_src  = cell_time[i-1];
         assign prev_src  = cell_prev[i-1];
      end

      if (i == PULSE_DEPTH - 1) begin : g_oldest
         assign older_hit = 1'b0;
      end else begin : g_younger
         assign older_hit = cell_hit[i+1];
      end

      phpt_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (cell_ctl),
         .valid        (count_ff > CNT_W'(i)),
         .newest       (i == 0),
         .value_in     (value_src),
         .time_in      (time_src),
         .prev_in      (prev_src),
         .older_hit_in (older_hit),
         .value_out    (cell_value[i]),
         .time_out     (cell_time[i]),
         .prev_out     (cell_prev[i]),
         .hit_out      (cell_hit[i]),
         .sel          (sel_vec[i]),
         .sel_time     (cell_sel_time[i]),
         .sel_prev     (cell_sel_prev[i])
      );
   end

   // Gather the times of the one selected cell.
   always_comb begin
      sel_time_any = '0;
      sel_prev_any = '0;
      for (int i = 0; i < PULSE_DEPTH; i++) begin
         sel_time_any = sel_time_any | cell_sel_time[i];
         sel_prev_any = sel_prev_any | cell_sel_prev[i];
      end
      t2_in = {1'b0, sel_time_ff} + {1'b0, sel_prev_ff};
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SELECT) begin
         sel_time_ff <= sel_time_any;
         sel_prev_ff <= sel_prev_any;
      end
      if (state_ff == ST_SUM) begin
         t2_ff <= t2_in;
      end
   end

   // Sequencer for sample handling, the edge search and result generation.
   always_comb begin
      state_in     = state_ff;
      in_pulse_in  = in_pulse_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      prev_time_in = prev_time_ff;
      hits_in      = hits_ff;
      eor_pend_in  = eor_pend_ff;
      q_push       = 1'b0;
      q_data       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               prev_time_in = sample_time;
               if (start_pulse) begin
                  in_pulse_in = 1'b1;
                  peak_in     = sample_value;
                  count_in    = CNT_W'(1);
               end else if (close_pulse) begin
                  in_pulse_in = 1'b0;
                  eor_pend_in = req_tlast;
                  state_in    = ST_MATCH;
               end else if (in_pulse_ff) begin
                  if (rising ? (sample_value > peak_ff) : (sample_value < peak_ff)) begin
                     peak_in = sample_value;
                  end
                  if (store) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               // Record end without a detection: the count goes out at once.
               if (req_tlast && !close_pulse) begin
                  in_pulse_in = 1'b0;
                  count_in    = '0;
                  hits_in     = '0;
                  q_push      = 1'b1;
                  q_data.kind = phpt_pkg::KIND_COUNT;
                  q_data.hits = hits_ff;
                  q_data.last = 1'b1;
               end
            end
         end
         ST_MATCH: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_WINDOW;
         end
         ST_WINDOW: begin
            if (!q_full) begin
               q_push           = 1'b1;
               q_data.kind      = phpt_pkg::KIND_DETECT;
               q_data.time_x2   = t2_ff;
               q_data.in_window = in_window;
               q_data.last      = !eor_pend_ff;
               if (in_window && (hits_ff != phpt_pkg::HITS_MAX)) begin
                  hits_in = hits_ff + phpt_pkg::HITS_W'(1);
               end
               count_in = '0;
               state_in = eor_pend_ff ? ST_COUNT : ST_IDLE;
            end
         end
         ST_COUNT: begin
            if (!q_full) begin
               q_push      = 1'b1;
               q_data.kind = phpt_pkg::KIND_COUNT;
               q_data.hits = hits_ff;
               q_data.last = 1'b1;
               hits_in     = '0;
               eor_pend_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_pulse_ff  <= 1'b0;
         peak_ff      <= '0;
         count_ff     <= '0;
         prev_time_ff <= '0;
         hits_ff      <= '0;
         eor_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_pulse_ff  <= in_pulse_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         prev_time_ff <= prev_time_in;
         hits_ff      <= hits_in;
         eor_pend_ff  <= eor_pend_in;
      end
   end

   // Result queue and channel packing.
   phpt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {6'b0, rsp_data.hits, rsp_data.in_window, rsp_data.time_x2};
   assign rsp_tuser = rsp_data.kind;
   assign rsp_tlast = rsp_data.last;

`ifndef NO_ASSERTIONS
   // A sample that ends a pulse starts the edge search.
   a_close_starts_search: assert property (@(posedge clock) disable iff (reset)
      (req_fire && close_pulse) |=> (state_ff == ST_MATCH))
      else $error("closing sample did not start the edge search");

   // An open pulse always has at least one buffered sample.
   a_open_has_sample: assert property (@(posedge clock) disable iff (reset)
      in_pulse_ff |-> (count_ff != '0))
      else $error("open pulse with an empty cell row");

   // The fill count never passes the row length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PULSE_DEPTH))
      else $error("fill count beyond the cell row");

   // Exactly one cell is chosen as the edge during selection.
   a_one_edge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SELECT) |-> $onehot(sel_vec))
      else $error("edge selection is not one-hot");

   // A result is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("result pushed into a full queue");
`endif

endmodule

[design/phpt_cell.sv]
// ----------------------------------------------------------------------------
// Pulse sample cell
// Holds one buffered sample with its time and the time of the sample before
// it. Samples move one cell along the row on every store. On a search each
// cell compares its doubled value with the half level and passes an
// "older hit" flag towards the newest cell, so that the oldest match wins.
// ----------------------------------------------------------------------------
module phpt_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  phpt_pkg::cell_ctl_type               ctl,
   input  logic                                 valid,
   input  logic                                 newest,
   input  logic signed [phpt_pkg::VALUE_W-1:0]  value_in,
   input  logic [phpt_pkg::TIME_W-1:0]          time_in,
   input  logic [phpt_pkg::TIME_W-1:0]          prev_in,
   input  logic                                 older_hit_in,
   output logic signed [phpt_pkg::VALUE_W-1:0]  value_out,
   output logic [phpt_pkg::TIME_W-1:0]          time_out,
   output logic [phpt_pkg::TIME_W-1:0]          prev_out,
   output logic                                 hit_out,
   output logic                                 sel,
   output logic [phpt_pkg::TIME_W-1:0]          sel_time,
   output logic [phpt_pkg::TIME_W-1:0]          sel_prev
);

   logic signed [phpt_pkg::VALUE_W-1:0] value_ff, value_in_w;
   logic [phpt_pkg::TIME_W-1:0]         time_ff, time_in_w;
   logic [phpt_pkg::TIME_W-1:0]         prev_ff, prev_in_w;
   logic                                match_ff, match_in;
   logic signed [phpt_pkg::LEVEL_W-1:0] doubled;
   logic                                reaches;
   logic                                match_eff;

   // Sample storage moves along the row on a store.
   always_comb begin
      value_in_w = ctl.shift ? value_in : value_ff;
      time_in_w  = ctl.shift ? time_in  : time_ff;
      prev_in_w  = ctl.shift ? prev_in  : prev_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in_w;
      time_ff  <= time_in_w;
      prev_ff  <= prev_in_w;
   end

   // Exact half-level test on doubled values.
   always_comb begin
      doubled  = $signed({value_ff, 1'b0});
      reaches  = ctl.rising ? (doubled >= ctl.level) : (doubled <= ctl.level);
      match_in = ctl.evaluate ? (valid & reaches) : match_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   // The newest cell is the fallback edge when nothing reaches the level.
   always_comb begin
      match_eff = match_ff | newest;
      sel       = match_eff & ~older_hit_in;
      hit_out   = older_hit_in | match_eff;
      sel_time  = sel ? time_ff : '0;
      sel_prev  = sel ? prev_ff : '0;
   end

   assign value_out = value_ff;
   assign time_out  = time_ff;
   assign prev_out  = prev_ff;

endmodule

[design/phpt_rsp_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue between the result logic and the result channel, so that
// both results of one sample can wait while the receiver stalls.
// ----------------------------------------------------------------------------
module phpt_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  phpt_pkg::result_type     push_data,
   output logic                     full,
   output logic                     out_valid,
   input  logic                     out_ready,
   output phpt_pkg::result_type     out_data
);

   phpt_pkg::result_type entry_ff [2];
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;

   // Pointer and occupancy update.
   always_comb begin
      pop       = out_valid & out_ready;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = count_ff[1];
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule

[sim/phpt_checker.sv]
// ----------------------------------------------------------------------------
// Pulse half-peak timing counter: result checker
// Watches the sample, result and register channels of the block. Every
// accepted sample is run through a local copy of the discriminator, and the
// results it causes are queued. Every accepted result is compared field by
// field with the oldest queued one. The failure count and the number of
// results still owed are handed to the test top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module phpt_checker #(
   parameter int PULSE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          results_owed
);

   // Local copy of the registers
   logic signed [phpt_pkg::VALUE_W-1:0] cfg_baseline;
   logic signed [phpt_pkg::VALUE_W-1:0] cfg_threshold;
   logic [phpt_pkg::TIME_W-1:0]         cfg_win_start;
   logic [phpt_pkg::TIME_W-1:0]         cfg_win_end;

   // Local copy of the discriminator state
   logic                                pulse_open;
   logic signed [phpt_pkg::VALUE_W-1:0] pulse_peak;
   logic signed [phpt_pkg::VALUE_W-1:0] cell_value [PULSE_DEPTH];
   logic [phpt_pkg::TIME_W-1:0]         cell_time [PULSE_DEPTH];
   int                                  cells_used;
   logic [phpt_pkg::TIME_W-1:0]         lead_time;
   logic [phpt_pkg::TIME_W-1:0]         last_time;
   logic [phpt_pkg::HITS_W-1:0]         record_hits;

   // Detections and record counts that the block still owes
   phpt_pkg::result_type due_results [$];
   int                   mismatches = 0;

   assign fail_count = mismatches;

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Compare one result transfer with the oldest owed result.
   task automatic check_result();
      phpt_pkg::result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("result with nothing owed", 64'(rsp_tdata), 64'd0);
      end else begin
         want = due_results.pop_front();
         if (rsp_tuser !== want.kind)
            report_mismatch("item_kind", 64'(rsp_tuser), 64'(want.kind));
         if (rsp_tdata[32:0] !== want.time_x2)
            report_mismatch("detect_time_x2", 64'(rsp_tdata[32:0]),
                            64'(want.time_x2));
         if (rsp_tdata[33] !== want.in_window)
            report_mismatch("in_window", 64'(rsp_tdata[33]), 64'(want.in_window));
         if (rsp_tdata[49:34] !== want.hits)
            report_mismatch("hit_count", 64'(rsp_tdata[49:34]), 64'(want.hits));
         if (rsp_tdata[55:50] !== 6'd0)
            report_mismatch("tdata padding", 64'(rsp_tdata[55:50]), 64'd0);
         if (rsp_tlast !== want.last)
            report_mismatch("last_of_run", 64'(rsp_tlast), 64'(want.last));
      end
   endtask

   // Run one sample through the discriminator and queue what it causes.
   task automatic track_sample(input logic signed [phpt_pkg::VALUE_W-1:0] value,
                               input logic [phpt_pkg::TIME_W-1:0] stamp,
                               input logic ends_record);
      phpt_pkg::result_type          made [2];
      int                            made_n;
      int                            base;
      int                            thr;
      int                            level;
      int                            doubled;
      int                            used;
      int                            edge_at;
      bit                            rising;
      bit                            over;
      bit                            found;
      logic [phpt_pkg::T2_W:0]       sum2;
      logic [phpt_pkg::T2_W:0]       low2;
      logic [phpt_pkg::T2_W:0]       high2;
      logic [phpt_pkg::TIME_W-1:0]   prior;
      made_n = 0;
      base   = int'(cfg_baseline);
      thr    = int'(cfg_threshold);
      rising = thr > base;
      over   = rising ? (int'(value) > thr) : (int'(value) < thr);

      if (!pulse_open && over) begin
         // First sample beyond the threshold opens a pulse
         pulse_open    = 1'b1;
         pulse_peak    = value;
         lead_time     = last_time;
         cell_value[0] = value;
         cell_time[0]  = stamp;
         cells_used    = 1;
      end else if (pulse_open && !over) begin
         // Pulse closes: find the first cell at or past the half level
         level = int'(pulse_peak) + base;
         used  = cells_used;
         if (used < 1) used = 1;
         if (used > PULSE_DEPTH) used = PULSE_DEPTH;
         edge_at = used - 1;
         found   = 1'b0;
         for (int i = 0; i < used; i++) begin
            doubled = 2 * int'(cell_value[i]);
            if (!found && (rising ? (doubled >= level) : (doubled <= level))) begin
               edge_at = i;
               found   = 1'b1;
            end
         end
         if (edge_at == 0) prior = lead_time;
         else prior = cell_time[edge_at-1];
         sum2  = {2'b00, cell_time[edge_at]} + {2'b00, prior};
         low2  = {1'b0, cfg_win_start, 1'b0};
         high2 = {1'b0, cfg_win_end, 1'b0};
         made[made_n].kind      = phpt_pkg::KIND_DETECT;
         made[made_n].time_x2   = sum2[phpt_pkg::T2_W-1:0];
         made[made_n].in_window = (sum2 > low2) && (sum2 < high2);
         made[made_n].hits      = '0;
         made[made_n].last      = 1'b0;
         if (made[made_n].in_window && record_hits != phpt_pkg::HITS_MAX)
            record_hits++;
         made_n++;
         pulse_open = 1'b0;
         cells_used = 0;
      end else if (pulse_open) begin
         // Pulse goes on: follow the peak, buffer while there is room
         if (rising ? (value > pulse_peak) : (value < pulse_peak)) pulse_peak = value;
         if (cells_used < PULSE_DEPTH) begin
            cell_value[cells_used] = value;
            cell_time[cells_used]  = stamp;
            cells_used++;
         end
      end

      last_time = stamp;

      // Record end: report the hit count, drop any open pulse
      if (ends_record) begin
         pulse_open = 1'b0;
         cells_used = 0;
         made[made_n].kind      = phpt_pkg::KIND_COUNT;
         made[made_n].time_x2   = '0;
         made[made_n].in_window = 1'b0;
         made[made_n].hits      = record_hits;
         made[made_n].last      = 1'b0;
         made_n++;
         record_hits = '0;
      end

      if (made_n > 0) made[made_n-1].last = 1'b1;
      for (int k = 0; k < made_n; k++) due_results.push_back(made[k]);
   endtask

   // Follow every transfer on the three channels
   always @(posedge clock) begin
      if (reset) begin
         cfg_baseline  = phpt_pkg::BASELINE_RESET;
         cfg_threshold = phpt_pkg::THRESHOLD_RESET;
         cfg_win_start = phpt_pkg::WIN_START_RESET;
         cfg_win_end   = phpt_pkg::WIN_END_RESET;
         pulse_open    = 1'b0;
         pulse_peak    = '0;
         cells_used    = 0;
         lead_time     = '0;
         last_time     = '0;
         record_hits   = '0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               phpt_pkg::CSR_BASELINE:  cfg_baseline  = csr_data[phpt_pkg::VALUE_W-1:0];
               phpt_pkg::CSR_THRESHOLD: cfg_threshold = csr_data[phpt_pkg::VALUE_W-1:0];
               phpt_pkg::CSR_WIN_START: cfg_win_start = csr_data;
               phpt_pkg::CSR_WIN_END:   cfg_win_end   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            track_sample(req_tdata[15:0], req_tdata[47:16], req_tlast);
      end
      results_owed <= due_results.size();
   end

endmodule

[sim/pulse_half_peak_timing_counter_top_test.sv]
// ----------------------------------------------------------------------------
// Pulse half-peak timing counter: test top
// Drives samples, register writes and result back-pressure into the block and
// leaves all prediction and comparison to the checker beside it. A short
// directed run is followed by phases of random records under several register
// settings and a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pulse_half_peak_timing_counter_top_test;

   localparam int DEPTH         = 64;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASES        = 10;
   localparam int IDLE_PERCENT  = 26;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [47:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic [1:0]  csr_index  = phpt_pkg::CSR_BASELINE;
   logic [31:0] csr_data   = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_ready;
   int          fail_count;
   int          results_owed;

   // Stimulus shaping
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;
   bit          hold_ask   = 1'b0;
   int          samples_sent = 0;
   logic [phpt_pkg::TIME_W-1:0]         tick_stamp = 32'd300;
   logic signed [phpt_pkg::VALUE_W-1:0] mirror_baseline  = phpt_pkg::BASELINE_RESET;
   logic signed [phpt_pkg::VALUE_W-1:0] mirror_threshold = phpt_pkg::THRESHOLD_RESET;
   int          record_levels [$];

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pulse_half_peak_timing_counter_top #(
      .PULSE_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   phpt_checker #(
      .PULSE_DEPTH(DEPTH)
   ) u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   function automatic bit rising_polarity();
      return mirror_threshold > mirror_baseline;
   endfunction

   // A level that stays on the quiet side of the threshold, now and then any
   // code at all.
   function automatic int quiet_level();
      logic signed [phpt_pkg::VALUE_W-1:0] any_code;
      int thr;
      int lo;
      int hi;
      thr = int'(mirror_threshold);
      if ($urandom_range(0, 9) == 0) begin
         any_code = 16'($urandom);
         return int'(any_code);
      end
      if (rising_polarity()) begin
         lo = (thr - 400 < -32768) ? -32768 : thr - 400;
         hi = thr;
      end else begin
         lo = thr;
         hi = (thr + 400 > 32767) ? 32767 : thr + 400;
      end
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Build one record: quiet stretches and pulses of random shape.
   task automatic build_record();
      int  thr;
      int  span;
      int  len;
      int  peak_step;
      int  top_at;
      int  lvl;
      bit  rising;
      bit  ramp;
      record_levels.delete();
      thr    = int'(mirror_threshold);
      rising = rising_polarity();
      span   = rising ? 32767 - thr : thr + 32768;
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(0, 5)) record_levels.push_back(quiet_level());
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 8);
         if (span == 0) begin
            repeat (len) record_levels.push_back(quiet_level());
         end else begin
            peak_step = 1 + $urandom_range(0,
               ($urandom_range(0, 3) == 0 || span <= 3000) ? span - 1 : 2999);
            top_at = $urandom_range(0, len - 1);
            ramp   = 1'($urandom_range(0, 1));
            for (int i = 0; i < len; i++) begin
               if (i == top_at) lvl = peak_step;
               else if (ramp && i < top_at) lvl = 1 + ((peak_step - 1) * (i + 1)) / (top_at + 1);
               else lvl = 1 + $urandom_range(0, peak_step - 1);
               record_levels.push_back(rising ? thr + lvl : thr - lvl);
            end
         end
      end
      // No quiet tail leaves a pulse open at record end; one closes it there
      repeat ($urandom_range(0, 3)) record_levels.push_back(quiet_level());
      if (record_levels.size() == 0) record_levels.push_back(quiet_level());
   endtask

   // Offer one sample and wait for its transfer, idling first at random.
   task automatic send_sample(input int value, input logic [phpt_pkg::TIME_W-1:0] when,
                              input bit closes);
      logic signed [phpt_pkg::VALUE_W-1:0] code;
      code = 16'(value);
      if (!req_steady) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {when, code};
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // Send a record; cut short, it stops midway without a record end.
   task automatic send_record(input bit cut_short);
      int count;
      build_record();
      count = cut_short ? record_levels.size() / 2 + 1 : record_levels.size();
      for (int i = 0; i < count; i++) begin
         tick_stamp += $urandom_range(1, 3);
         send_sample(record_levels[i], tick_stamp, !cut_short && i == count - 1);
      end
   endtask

   task automatic run_stream(input int budget);
      int start;
      start = samples_sent;
      while (samples_sent - start < budget) send_record(1'b0);
      // Sometimes leave a pulse open across the next register change
      if ($urandom_range(0, 1)) send_record(1'b1);
   endtask

   // Stop offering, wait for every owed result, then let the block settle.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; csr_valid is lowered by the caller after a batch.
   task automatic set_register(input logic [1:0] index, input logic [31:0] value);
      case (index)
         phpt_pkg::CSR_BASELINE:  mirror_baseline  = value[phpt_pkg::VALUE_W-1:0];
         phpt_pkg::CSR_THRESHOLD: mirror_threshold = value[phpt_pkg::VALUE_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_settings(input logic signed [phpt_pkg::VALUE_W-1:0] base,
                                 input logic signed [phpt_pkg::VALUE_W-1:0] thr,
                                 input logic [phpt_pkg::TIME_W-1:0] win_lo,
                                 input logic [phpt_pkg::TIME_W-1:0] win_hi);
      set_register(phpt_pkg::CSR_BASELINE, {{16{base[phpt_pkg::VALUE_W-1]}}, base});
      set_register(phpt_pkg::CSR_THRESHOLD, {{16{thr[phpt_pkg::VALUE_W-1]}}, thr});
      set_register(phpt_pkg::CSR_WIN_START, win_lo);
      set_register(phpt_pkg::CSR_WIN_END, win_hi);
      csr_valid <= 1'b0;
   endtask

   // Register settings for each random phase, extremes among them.
   task automatic configure_phase(input int p);
      logic signed [phpt_pkg::VALUE_W-1:0] base;
      logic signed [phpt_pkg::VALUE_W-1:0] thr;
      logic [phpt_pkg::TIME_W-1:0]         win_lo;
      logic [phpt_pkg::TIME_W-1:0]         win_hi;
      case (p)
         0: begin base = 16'sd0;     thr = 16'sd100;   end
         1: begin base = 16'sd0;     thr = -16'sd100;  end
         2: begin base = 16'sh8000;  thr = 16'sh7FFF;  end
         3: begin base = 16'sh7FFF;  thr = 16'sh8000;  end
         4: begin base = 16'($urandom); thr = base;    end
         5: begin base = 16'sh8000;  thr = 16'(-32767 + int'($urandom_range(0, 500))); end
         6: begin base = 16'sh7FFF;  thr = 16'(32766 - int'($urandom_range(0, 500)));  end
         default: begin base = 16'($urandom); thr = 16'($urandom); end
      endcase
      // Timestamps jump now and then, once to just short of wrapping
      if (p == 8) tick_stamp = 32'hFFFF_FF00;
      else if (p % 3 == 2) tick_stamp = $urandom;
      case (p % 5)
         1: begin win_lo = 32'h0000_0000; win_hi = 32'hFFFF_FFFF; end
         2: begin win_lo = 32'hFFFF_FFFF; win_hi = 32'h0000_0000; end
         3: begin win_lo = $urandom;      win_hi = $urandom;      end
         default: begin
            win_lo = tick_stamp + $urandom_range(0, 300);
            win_hi = win_lo + $urandom_range(0, 600);
         end
      endcase
      write_settings(base, thr, win_lo, win_hi);
   endtask

   // The receiver stalls for a long hold-off while samples keep coming and fill the block.
   task automatic hold_receiver_burst();
      req_steady = 1'b1;
      hold_ask   = 1'b1;
      repeat (40) begin
         tick_stamp += 1;
         send_sample(quiet_level(), tick_stamp, 1'b1);
      end
      req_steady = 1'b0;
   endtask

   // Result receiver: random stalls, a long hold-off on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= rsp_steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: too long without any transfer ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // Main sequence
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings. A pulse right after reset
      // takes time zero as the sample before it.
      send_sample(200, 32'd10, 1'b0);
      send_sample(50, 32'd11, 1'b0);
      // Extreme codes; the closing sample also ends the record
      send_sample(32767, 32'd20, 1'b0);
      send_sample(-32768, 32'd21, 1'b1);
      // Largest timestamps, doubled time needs the top bit
      send_sample(0, 32'hFFFF_FFFE, 1'b0);
      send_sample(300, 32'hFFFF_FFFF, 1'b0);
      send_sample(0, 32'h0000_0000, 1'b0);
      // Rising edge: half level first reached on the third cell
      send_sample(150, 32'd100, 1'b0);
      send_sample(300, 32'd101, 1'b0);
      send_sample(1000, 32'd102, 1'b0);
      send_sample(800, 32'd103, 1'b0);
      send_sample(0, 32'd104, 1'b0);
      // Level equal to the threshold is not over it; a pulse still open at
      // record end is dropped
      send_sample(100, 32'd105, 1'b0);
      send_sample(101, 32'd106, 1'b0);
      send_sample(101, 32'd107, 1'b1);
      // Record with no pulse at all
      send_sample(-5, 32'd108, 1'b1);
      // The sample before the pulse belongs to the previous record
      send_sample(32767, 32'd201, 1'b0);
      send_sample(32767, 32'd202, 1'b0);
      send_sample(100, 32'd203, 1'b1);

      // Random phases under changing settings
      for (int p = 0; p < PHASES; p++) begin
         finish_phase();
         configure_phase(p);
         if (p == 7) begin
            req_steady = 1'b1;
            rsp_steady = 1'b1;
         end
         run_stream((p == 2 || p == 3) ? 40 : 125);
         if (p == 0) hold_receiver_burst();
         req_steady = 1'b0;
         rsp_steady = 1'b0;
      end

      finish_phase();

      if (fail_count == 0 && results_owed == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
design/phpt_pkg.sv
design/phpt_cell.sv
design/phpt_rsp_queue.sv
design/pulse_half_peak_timing_counter_top.sv
sim/phpt_checker.sv
sim/pulse_half_peak_timing_counter_top_test.sv
